// File: rtl/segi_pkg.sv
// ----------------------------------------------------------------------------
// Segment intersection package
// Shared outcome codes, field positions and the side-band record that travels
// beside the arithmetic datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package segi_pkg;

   // Width of every coordinate field on the ports
   localparam int FIELD_W = 32;

   // Position of each endpoint coordinate within the request
   localparam int CI_AX1 = 0;
   localparam int CI_AY1 = 1;
   localparam int CI_AX2 = 2;
   localparam int CI_AY2 = 3;
   localparam int CI_BX1 = 4;
   localparam int CI_BY1 = 5;
   localparam int CI_BX2 = 6;
   localparam int CI_BY2 = 7;
   localparam int N_COORDS = 8;

   typedef enum logic [2:0] {
      OC_BOX_DISJOINT = 3'd0,
      OC_PARALLEL     = 3'd1,
      OC_OUTSIDE      = 3'd2,
      OC_AT_START     = 3'd3,
      OC_AT_END       = 3'd4,
      OC_COMPUTED     = 3'd5
   } outcome_type;

   // Decision and endpoint data carried alongside the division
   typedef struct packed {
      outcome_type               outcome;
      logic                      exact;
      logic signed [FIELD_W-1:0] pt_x;
      logic signed [FIELD_W-1:0] pt_y;
   } side_type;

endpackage

`default_nettype wire

// File: rtl/segi_front.sv
// ----------------------------------------------------------------------------
// Segment intersection front end
// Three stages: direction vectors and early tests, the six cross products,
// then the denominator and the two line-parameter numerators.
// ----------------------------------------------------------------------------
`default_nettype none

module segi_front #(
   parameter int COORD_BITS = 32
) (
   input  wire logic                                            clock,
   input  wire logic                                            reset,
   input  wire logic                                            en,
   input  wire logic                                            in_valid,
   input  wire logic [segi_pkg::N_COORDS-1:0][segi_pkg::FIELD_W-1:0] in_coords,
   input  wire logic                                            in_exact,
   output logic                                                 out_valid,
   output segi_pkg::side_type                                   out_side,
   output logic signed [2*COORD_BITS+2:0]                       out_div,
   output logic signed [2*COORD_BITS+2:0]                       out_num,
   output logic signed [2*COORD_BITS+2:0]                       out_mu,
   output logic signed [COORD_BITS:0]                           out_adx,
   output logic signed [COORD_BITS:0]                           out_ady,
   output logic signed [COORD_BITS-1:0]                         out_base_x,
   output logic signed [COORD_BITS-1:0]                         out_base_y
);

   localparam int CB = COORD_BITS;
   localparam int DW = CB + 1;
   localparam int PW = 2 * CB + 2;
   localparam int SW = 2 * CB + 3;

   logic signed [CB-1:0] ax1, ay1, ax2, ay2, bx1, by1, bx2, by2;
   logic signed [CB-1:0] a_max_x, a_min_x, a_max_y, a_min_y;
   logic signed [CB-1:0] b_max_x, b_min_x, b_max_y, b_min_y;
   logic                 disjoint;

   // stage 1
   logic                 v1_ff;
   segi_pkg::side_type   side1_in, side1_ff;
   logic signed [DW-1:0] adx_in, ady_in, bdx_in, bdy_in, ex_in, ey_in;
   logic signed [DW-1:0] adx1_ff, ady1_ff, bdx1_ff, bdy1_ff, ex1_ff, ey1_ff;
   logic signed [CB-1:0] bx1_ff, by1_ff;

   // stage 2
   logic                 v2_ff;
   segi_pkg::side_type   side2_ff;
   logic signed [PW-1:0] pda_in, pdb_in, pna_in, pnb_in, pma_in, pmb_in;
   logic signed [PW-1:0] pda_ff, pdb_ff, pna_ff, pnb_ff, pma_ff, pmb_ff;
   logic signed [DW-1:0] adx2_ff, ady2_ff;
   logic signed [CB-1:0] bx2_ff, by2_ff;

   // stage 3
   logic                 v3_ff;
   segi_pkg::side_type   side3_ff;
   logic signed [SW-1:0] div_in, num_in, mu_in;
   logic signed [SW-1:0] div_ff, num_ff, mu_ff;
   logic signed [DW-1:0] adx3_ff, ady3_ff;
   logic signed [CB-1:0] bx3_ff, by3_ff;

   // take the low coordinate bits of each field
   assign ax1 = $signed(in_coords[segi_pkg::CI_AX1][CB-1:0]);
   assign ay1 = $signed(in_coords[segi_pkg::CI_AY1][CB-1:0]);
   assign ax2 = $signed(in_coords[segi_pkg::CI_AX2][CB-1:0]);
   assign ay2 = $signed(in_coords[segi_pkg::CI_AY2][CB-1:0]);
   assign bx1 = $signed(in_coords[segi_pkg::CI_BX1][CB-1:0]);
   assign by1 = $signed(in_coords[segi_pkg::CI_BY1][CB-1:0]);
   assign bx2 = $signed(in_coords[segi_pkg::CI_BX2][CB-1:0]);
   assign by2 = $signed(in_coords[segi_pkg::CI_BY2][CB-1:0]);

   // bounding boxes
   assign a_max_x = (ax1 > ax2) ? ax1 : ax2;
   assign a_min_x = (ax1 < ax2) ? ax1 : ax2;
   assign a_max_y = (ay1 > ay2) ? ay1 : ay2;
   assign a_min_y = (ay1 < ay2) ? ay1 : ay2;
   assign b_max_x = (bx1 > bx2) ? bx1 : bx2;
   assign b_min_x = (bx1 < bx2) ? bx1 : bx2;
   assign b_max_y = (by1 > by2) ? by1 : by2;
   assign b_min_y = (by1 < by2) ? by1 : by2;
   assign disjoint = (a_max_x < b_min_x) || (a_min_x > b_max_x) ||
                     (a_max_y < b_min_y) || (a_min_y > b_max_y);

   // early decision and direction vectors
   always_comb begin
      side1_in.exact   = in_exact;
      side1_in.pt_x    = segi_pkg::FIELD_W'(ax1);
      side1_in.pt_y    = segi_pkg::FIELD_W'(ay1);
      side1_in.outcome = segi_pkg::OC_COMPUTED;
      if (in_exact && disjoint) begin
         side1_in.outcome = segi_pkg::OC_BOX_DISJOINT;
      end else if ((ax1 == bx1 && ay1 == by1) || (ax1 == bx2 && ay1 == by2)) begin
         side1_in.outcome = segi_pkg::OC_AT_START;
      end else if ((ax2 == bx1 && ay2 == by1) || (ax2 == bx2 && ay2 == by2)) begin
         side1_in.outcome = segi_pkg::OC_AT_END;
         side1_in.pt_x    = segi_pkg::FIELD_W'(ax2);
         side1_in.pt_y    = segi_pkg::FIELD_W'(ay2);
      end
      adx_in = DW'(ax2) - DW'(ax1);
      ady_in = DW'(ay2) - DW'(ay1);
      bdx_in = DW'(bx2) - DW'(bx1);
      bdy_in = DW'(by2) - DW'(by1);
      ex_in  = DW'(bx1) - DW'(ax1);
      ey_in  = DW'(by1) - DW'(ay1);
   end

   // cross products
   always_comb begin
      pda_in = PW'(adx1_ff) * PW'(bdy1_ff);
      pdb_in = PW'(bdx1_ff) * PW'(ady1_ff);
      pna_in = PW'(ex1_ff) * PW'(bdy1_ff);
      pnb_in = PW'(bdx1_ff) * PW'(ey1_ff);
      pma_in = PW'(ex1_ff) * PW'(ady1_ff);
      pmb_in = PW'(adx1_ff) * PW'(ey1_ff);
   end

   // denominator and numerators
   always_comb begin
      div_in = SW'(pda_ff) - SW'(pdb_ff);
      num_in = SW'(pna_ff) - SW'(pnb_ff);
      mu_in  = SW'(pma_ff) - SW'(pmb_ff);
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (en) begin
         side1_ff <= side1_in;
         adx1_ff  <= adx_in;
         ady1_ff  <= ady_in;
         bdx1_ff  <= bdx_in;
         bdy1_ff  <= bdy_in;
         ex1_ff   <= ex_in;
         ey1_ff   <= ey_in;
         bx1_ff   <= ax1;
         by1_ff   <= ay1;
         side2_ff <= side1_ff;
         pda_ff   <= pda_in;
         pdb_ff   <= pdb_in;
         pna_ff   <= pna_in;
         pnb_ff   <= pnb_in;
         pma_ff   <= pma_in;
         pmb_ff   <= pmb_in;
         adx2_ff  <= adx1_ff;
         ady2_ff  <= ady1_ff;
         bx2_ff   <= bx1_ff;
         by2_ff   <= by1_ff;
         side3_ff <= side2_ff;
         div_ff   <= div_in;
         num_ff   <= num_in;
         mu_ff    <= mu_in;
         adx3_ff  <= adx2_ff;
         ady3_ff  <= ady2_ff;
         bx3_ff   <= bx2_ff;
         by3_ff   <= by2_ff;
      end
   end

   assign out_valid  = v3_ff;
   assign out_side   = side3_ff;
   assign out_div    = div_ff;
   assign out_num    = num_ff;
   assign out_mu     = mu_ff;
   assign out_adx    = adx3_ff;
   assign out_ady    = ady3_ff;
   assign out_base_x = bx3_ff;
   assign out_base_y = by3_ff;

endmodule

`default_nettype wire

// File: rtl/segi_scale.sv
// ----------------------------------------------------------------------------
// Segment intersection scaling stages
// Three stages: magnitudes, signs and the unit-interval tests, then split
// partial products of the numerator by each direction, then their sum.
// ----------------------------------------------------------------------------
`default_nettype none

module segi_scale #(
   parameter int COORD_BITS = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          en,
   input  wire logic                          in_valid,
   input  wire segi_pkg::side_type            in_side,
   input  wire logic signed [2*COORD_BITS+2:0] in_div,
   input  wire logic signed [2*COORD_BITS+2:0] in_num,
   input  wire logic signed [2*COORD_BITS+2:0] in_mu,
   input  wire logic signed [COORD_BITS:0]    in_adx,
   input  wire logic signed [COORD_BITS:0]    in_ady,
   input  wire logic signed [COORD_BITS-1:0]  in_base_x,
   input  wire logic signed [COORD_BITS-1:0]  in_base_y,
   output logic                               out_valid,
   output segi_pkg::side_type                 out_side,
   output logic [3*COORD_BITS+2:0]            out_dvd_x,
   output logic [3*COORD_BITS+2:0]            out_dvd_y,
   output logic [2*COORD_BITS+1:0]            out_dvs,
   output logic                               out_neg_x,
   output logic                               out_neg_y,
   output logic signed [COORD_BITS-1:0]       out_base_x,
   output logic signed [COORD_BITS-1:0]       out_base_y
);

   localparam int CB = COORD_BITS;
   localparam int H  = CB + 1;
   localparam int MW = 2 * H;
   localparam int DW = 3 * H;
   localparam int SW = 2 * CB + 3;

   logic [MW-1:0] abs_div, abs_num, abs_mu;
   logic          num_unit, mu_unit;

   // stage 4
   logic                 v4_ff;
   segi_pkg::side_type   side4_in, side4_ff;
   logic [MW-1:0]        num4_ff, dvs4_ff;
   logic [H-1:0]         adx4_ff, ady4_ff;
   logic                 negx4_ff, negy4_ff;
   logic signed [CB-1:0] bx4_ff, by4_ff;

   // stage 5
   logic                 v5_ff;
   segi_pkg::side_type   side5_ff;
   logic [MW-1:0]        pxl_in, pxh_in, pyl_in, pyh_in;
   logic [MW-1:0]        pxl_ff, pxh_ff, pyl_ff, pyh_ff, dvs5_ff;
   logic                 negx5_ff, negy5_ff;
   logic signed [CB-1:0] bx5_ff, by5_ff;

   // stage 6
   logic                 v6_ff;
   segi_pkg::side_type   side6_ff;
   logic [DW-1:0]        dx_in, dy_in, dx6_ff, dy6_ff;
   logic [MW-1:0]        dvs6_ff;
   logic                 negx6_ff, negy6_ff;
   logic signed [CB-1:0] bx6_ff, by6_ff;

   // magnitudes and unit-interval tests
   always_comb begin
      abs_div  = in_div[SW-1] ? MW'(-in_div) : MW'(in_div);
      abs_num  = in_num[SW-1] ? MW'(-in_num) : MW'(in_num);
      abs_mu   = in_mu[SW-1]  ? MW'(-in_mu)  : MW'(in_mu);
      num_unit = ((abs_num == '0) || (in_num[SW-1] == in_div[SW-1])) && (abs_num <= abs_div);
      mu_unit  = ((abs_mu == '0) || (in_mu[SW-1] == in_div[SW-1])) && (abs_mu <= abs_div);
      side4_in = in_side;
      if (in_side.outcome == segi_pkg::OC_COMPUTED) begin
         if (abs_div == '0) begin
            side4_in.outcome = segi_pkg::OC_PARALLEL;
         end else if (in_side.exact && !(num_unit && mu_unit)) begin
            side4_in.outcome = segi_pkg::OC_OUTSIDE;
         end
      end
   end

   // split partial products
   always_comb begin
      pxl_in = MW'(num4_ff[H-1:0]) * MW'(adx4_ff);
      pxh_in = MW'(num4_ff[MW-1:H]) * MW'(adx4_ff);
      pyl_in = MW'(num4_ff[H-1:0]) * MW'(ady4_ff);
      pyh_in = MW'(num4_ff[MW-1:H]) * MW'(ady4_ff);
   end

   // recombine the halves
   always_comb begin
      dx_in = (DW'(pxh_ff) << H) + DW'(pxl_ff);
      dy_in = (DW'(pyh_ff) << H) + DW'(pyl_ff);
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else if (en) begin
         v4_ff <= in_valid;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (en) begin
         side4_ff <= side4_in;
         num4_ff  <= abs_num;
         dvs4_ff  <= abs_div;
         adx4_ff  <= in_adx[CB] ? H'(-in_adx) : H'(in_adx);
         ady4_ff  <= in_ady[CB] ? H'(-in_ady) : H'(in_ady);
         negx4_ff <= in_num[SW-1] ^ in_div[SW-1] ^ in_adx[CB];
         negy4_ff <= in_num[SW-1] ^ in_div[SW-1] ^ in_ady[CB];
         bx4_ff   <= in_base_x;
         by4_ff   <= in_base_y;
         side5_ff <= side4_ff;
         pxl_ff   <= pxl_in;
         pxh_ff   <= pxh_in;
         pyl_ff   <= pyl_in;
         pyh_ff   <= pyh_in;
         dvs5_ff  <= dvs4_ff;
         negx5_ff <= negx4_ff;
         negy5_ff <= negy4_ff;
         bx5_ff   <= bx4_ff;
         by5_ff   <= by4_ff;
         side6_ff <= side5_ff;
         dx6_ff   <= dx_in;
         dy6_ff   <= dy_in;
         dvs6_ff  <= dvs5_ff;
         negx6_ff <= negx5_ff;
         negy6_ff <= negy5_ff;
         bx6_ff   <= bx5_ff;
         by6_ff   <= by5_ff;
      end
   end

   assign out_valid  = v6_ff;
   assign out_side   = side6_ff;
   assign out_dvd_x  = dx6_ff;
   assign out_dvd_y  = dy6_ff;
   assign out_dvs    = dvs6_ff;
   assign out_neg_x  = negx6_ff;
   assign out_neg_y  = negy6_ff;
   assign out_base_x = bx6_ff;
   assign out_base_y = by6_ff;

endmodule

`default_nettype wire

// File: rtl/segi_div.sv
// ----------------------------------------------------------------------------
// Segment intersection divider
// Pipelined restoring divider, one quotient bit per stage, with an up-front
// overflow test, round half away from zero, offset add and clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module segi_div #(
   parameter int COORD_BITS = 32
) (
   input  wire logic                         clock,
   input  wire logic                         en,
   input  wire logic [3*COORD_BITS+2:0]      in_dvd,
   input  wire logic [2*COORD_BITS+1:0]      in_dvs,
   input  wire logic                         in_neg,
   input  wire logic signed [COORD_BITS-1:0] in_base,
   output logic signed [segi_pkg::FIELD_W-1:0] out_coord,
   output logic                              out_sat
);

   localparam int CB = COORD_BITS;
   localparam int MW = 2 * CB + 2;
   localparam int DW = 3 * CB + 3;
   localparam int QB = CB + 2;
   localparam int SQ = CB + 4;
   localparam logic signed [SQ-1:0] CMAX = $signed({5'b00000, {(CB-1){1'b1}}});
   localparam logic signed [SQ-1:0] CMIN = $signed({5'b11111, {(CB-1){1'b0}}});

   logic [MW-1:0]        rem_ff  [0:QB];
   logic [QB-1:0]        quo_ff  [0:QB];
   logic [QB-1:0]        low_ff  [0:QB];
   logic [MW-1:0]        dvs_ff  [0:QB];
   logic                 neg_ff  [0:QB];
   logic                 ov_ff   [0:QB];
   logic signed [CB-1:0] base_ff [0:QB];

   // round stage
   logic                 up_in;
   logic [QB:0]          qr_in, qr_ff;
   logic                 negr_ff, ovr_ff;
   logic signed [CB-1:0] baser_ff;

   // final stage
   logic signed [SQ-1:0] qs, off, sum;
   logic signed [SQ-1:0] res_in;
   logic                 sat_in;
   logic signed [segi_pkg::FIELD_W-1:0] coord_ff;
   logic                 sat_ff;

   // overflow test: quotient would not fit in QB bits
   always_ff @(posedge clock) begin
      if (en) begin
         ov_ff[0]   <= MW'(in_dvd[DW-1:QB]) >= in_dvs;
         rem_ff[0]  <= MW'(in_dvd[DW-1:QB]);
         low_ff[0]  <= in_dvd[QB-1:0];
         quo_ff[0]  <= '0;
         dvs_ff[0]  <= in_dvs;
         neg_ff[0]  <= in_neg;
         base_ff[0] <= in_base;
      end
   end

   // one quotient bit per stage
   for (genvar k = 1; k <= QB; k++) begin : g_step
      logic [MW:0]   trial;
      logic          ge;
      logic [MW-1:0] rem_in;

      always_comb begin
         trial  = {rem_ff[k-1], low_ff[k-1][QB-1]};
         ge     = trial >= {1'b0, dvs_ff[k-1]};
         rem_in = ge ? MW'(trial - {1'b0, dvs_ff[k-1]}) : trial[MW-1:0];
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            quo_ff[k]  <= {quo_ff[k-1][QB-2:0], ge};
            low_ff[k]  <= low_ff[k-1] << 1;
            dvs_ff[k]  <= dvs_ff[k-1];
            neg_ff[k]  <= neg_ff[k-1];
            ov_ff[k]   <= ov_ff[k-1];
            base_ff[k] <= base_ff[k-1];
         end
      end
   end

   // round half away from zero on the magnitude
   always_comb begin
      up_in = {rem_ff[QB], 1'b0} >= {1'b0, dvs_ff[QB]};
      qr_in = (QB + 1)'(quo_ff[QB]) + (QB + 1)'(up_in);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         qr_ff    <= qr_in;
         negr_ff  <= neg_ff[QB];
         ovr_ff   <= ov_ff[QB];
         baser_ff <= base_ff[QB];
      end
   end

   // add the offset to the start point and clamp
   always_comb begin
      qs     = $signed({1'b0, qr_ff});
      off    = negr_ff ? -qs : qs;
      sum    = SQ'(baser_ff) + off;
      res_in = sum;
      sat_in = 1'b0;
      if (ovr_ff) begin
         res_in = negr_ff ? CMIN : CMAX;
         sat_in = 1'b1;
      end else if (sum > CMAX) begin
         res_in = CMAX;
         sat_in = 1'b1;
      end else if (sum < CMIN) begin
         res_in = CMIN;
         sat_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         coord_ff <= segi_pkg::FIELD_W'(res_in);
         sat_ff   <= sat_in;
      end
   end

   assign out_coord = coord_ff;
   assign out_sat   = sat_ff;

endmodule

`default_nettype wire

// File: rtl/segment_intersection_top.sv
// Path from request to response: three front stages, three scaling stages,
//   COORD_BITS + 5 divider stages and the response register.
// Throughput: one request per cycle while the skid slot is free; the per-bit
// divider pipeline sets the depth.
// Reset: synchronous, active high; clears every valid bit, response slots included.
// ----------------------------------------------------------------------------
// Segment intersection top level
// Streams segment pairs in and crossing results out, with a response register
// and a skid slot so requests keep flowing while a response waits and the slot is free.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_intersection_top #(
   parameter int COORD_BITS = 32
) (
   input  wire logic         clock,
   input  wire logic         reset,
   // seg_a_start_x, seg_a_start_y, seg_a_end_x, seg_a_end_y,
   // seg_b_start_x, seg_b_start_y, seg_b_end_x, seg_b_end_y (32 bits each)
   input  wire logic [255:0] req_tdata,
   // exact_mode
   input  wire logic [0:0]   req_tuser,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // outcome[2:0], found[3], cross_x[35:4], cross_y[67:36], saturated[68], zero
   output logic [71:0]       rsp_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready
);

   localparam int CB     = COORD_BITS;
   localparam int DW     = 3 * CB + 3;
   localparam int MW     = 2 * CB + 2;
   localparam int SW     = 2 * CB + 3;
   localparam int DLY    = CB + 5;
   localparam int FW     = segi_pkg::FIELD_W;
   localparam int RSP_W  = 72;

   logic en;

   logic [segi_pkg::N_COORDS-1:0][FW-1:0] coords;

   logic                 fr_valid;
   segi_pkg::side_type   fr_side;
   logic signed [SW-1:0] fr_div, fr_num, fr_mu;
   logic signed [CB:0]   fr_adx, fr_ady;
   logic signed [CB-1:0] fr_bx, fr_by;

   logic                 sc_valid;
   segi_pkg::side_type   sc_side;
   logic [DW-1:0]        sc_dx, sc_dy;
   logic [MW-1:0]        sc_dvs;
   logic                 sc_negx, sc_negy;
   logic signed [CB-1:0] sc_bx, sc_by;

   logic signed [FW-1:0] dv_x, dv_y;
   logic                 dv_satx, dv_saty;

   logic                 dly_v_ff    [0:DLY-1];
   segi_pkg::side_type   dly_side_ff [0:DLY-1];

   logic                 pipe_v;
   logic [RSP_W-1:0]     pipe_d;
   segi_pkg::side_type   fin;
   logic signed [FW-1:0] fin_x, fin_y;
   logic                 fin_sat, fin_found;

   logic                 out_v_in, out_v_ff, skid_v_in, skid_v_ff;
   logic [RSP_W-1:0]     out_d_in, out_d_ff, skid_d_in, skid_d_ff;

   // the whole pipeline moves while the skid slot is free
   assign en         = !skid_v_ff;
   assign req_tready = en;

   assign coords = req_tdata;

   segi_front #(.COORD_BITS(CB)) u_front (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_valid   (req_tvalid),
      .in_coords  (coords),
      .in_exact   (req_tuser[0]),
      .out_valid  (fr_valid),
      .out_side   (fr_side),
      .out_div    (fr_div),
      .out_num    (fr_num),
      .out_mu     (fr_mu),
      .out_adx    (fr_adx),
      .out_ady    (fr_ady),
      .out_base_x (fr_bx),
      .out_base_y (fr_by)
   );

   segi_scale #(.COORD_BITS(CB)) u_scale (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_valid   (fr_valid),
      .in_side    (fr_side),
      .in_div     (fr_div),
      .in_num     (fr_num),
      .in_mu      (fr_mu),
      .in_adx     (fr_adx),
      .in_ady     (fr_ady),
      .in_base_x  (fr_bx),
      .in_base_y  (fr_by),
      .out_valid  (sc_valid),
      .out_side   (sc_side),
      .out_dvd_x  (sc_dx),
      .out_dvd_y  (sc_dy),
      .out_dvs    (sc_dvs),
      .out_neg_x  (sc_negx),
      .out_neg_y  (sc_negy),
      .out_base_x (sc_bx),
      .out_base_y (sc_by)
   );

   segi_div #(.COORD_BITS(CB)) u_div_x (
      .clock     (clock),
      .en        (en),
      .in_dvd    (sc_dx),
      .in_dvs    (sc_dvs),
      .in_neg    (sc_negx),
      .in_base   (sc_bx),
      .out_coord (dv_x),
      .out_sat   (dv_satx)
   );

   segi_div #(.COORD_BITS(CB)) u_div_y (
      .clock     (clock),
      .en        (en),
      .in_dvd    (sc_dy),
      .in_dvs    (sc_dvs),
      .in_neg    (sc_negy),
      .in_base   (sc_by),
      .out_coord (dv_y),
      .out_sat   (dv_saty)
   );

   // carry valid and decision beside the dividers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DLY; i++) begin
            dly_v_ff[i] <= 1'b0;
         end
      end else if (en) begin
         dly_v_ff[0] <= sc_valid;
         for (int i = 1; i < DLY; i++) begin
            dly_v_ff[i] <= dly_v_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dly_side_ff[0] <= sc_side;
         for (int i = 1; i < DLY; i++) begin
            dly_side_ff[i] <= dly_side_ff[i-1];
         end
      end
   end

   // select the reported point for the outcome
   always_comb begin
      fin       = dly_side_ff[DLY-1];
      fin_x     = '0;
      fin_y     = '0;
      fin_sat   = 1'b0;
      fin_found = 1'b0;
      case (fin.outcome)
         segi_pkg::OC_AT_START, segi_pkg::OC_AT_END: begin
            fin_x     = fin.pt_x;
            fin_y     = fin.pt_y;
            fin_found = 1'b1;
         end
         segi_pkg::OC_OUTSIDE: begin
            fin_x   = dv_x;
            fin_y   = dv_y;
            fin_sat = dv_satx | dv_saty;
         end
         segi_pkg::OC_COMPUTED: begin
            fin_x     = dv_x;
            fin_y     = dv_y;
            fin_sat   = dv_satx | dv_saty;
            fin_found = 1'b1;
         end
         default: begin
            fin_x = '0;
         end
      endcase
      pipe_v = dly_v_ff[DLY-1];
      pipe_d = {3'b000, fin_sat, fin_y, fin_x, fin_found, fin.outcome};
   end

   // response register and skid slot
   always_comb begin
      out_v_in  = out_v_ff;
      out_d_in  = out_d_ff;
      skid_v_in = skid_v_ff;
      skid_d_in = skid_d_ff;
      if (skid_v_ff) begin
         if (rsp_tready) begin
            out_d_in  = skid_d_ff;
            skid_v_in = 1'b0;
         end
      end else if (!out_v_ff || rsp_tready) begin
         out_v_in = pipe_v;
         out_d_in = pipe_d;
      end else if (pipe_v) begin
         skid_v_in = 1'b1;
         skid_d_in = pipe_d;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         out_v_ff  <= out_v_in;
         skid_v_ff <= skid_v_in;
      end
   end

   always_ff @(posedge clock) begin
      out_d_ff  <= out_d_in;
      skid_d_ff <= skid_d_in;
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_d_ff;

endmodule

`default_nettype wire

// File: dv/segi_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment intersection checker
// Watches the request and response streams, predicts each crossing result in
// exact wide integer arithmetic and compares every response field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module segi_checker #(
   parameter int COORD_BITS = 32
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic [255:0] req_tdata,
   input  wire logic [0:0]   req_tuser,
   input  wire logic         req_tvalid,
   input  wire logic         req_tready,
   input  wire logic [71:0]  rsp_tdata,
   input  wire logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   output int                fail_count,
   output int                pending,
   output int                rsp_seen,
   output int                outcome_hits [6]
);

   typedef logic signed [199:0] wide_type;

   typedef struct packed {
      segi_pkg::outcome_type     outcome;
      logic                      found;
      logic signed [31:0]        cx;
      logic signed [31:0]        cy;
      logic                      sat;
   } crossing_type;

   crossing_type crossing_q[$];

   // Sign-extend the used low bits of a coordinate field
   function automatic wide_type field_coord(logic [31:0] v);
      wide_type w;
      w = wide_type'($signed(v << (32 - COORD_BITS)));
      return w >>> (32 - COORD_BITS);
   endfunction

   function automatic wide_type absw(wide_type v);
      return v < 0 ? -v : v;
   endfunction

   // Divide rounding half away from zero
   function automatic wide_type div_round(wide_type n, wide_type d);
      wide_type q, r;
      q = absw(n) / absw(d);
      r = absw(n) % absw(d);
      if (2 * r >= absw(d)) q = q + 1;
      return ((n < 0) != (d < 0)) ? -q : q;
   endfunction

   function automatic logic in_unit(wide_type n, wide_type d);
      return (n == 0 || ((n < 0) == (d < 0))) && absw(n) <= absw(d);
   endfunction

   // Clamp to the signed coordinate range
   function automatic logic [31:0] clamp(wide_type v, inout logic sat);
      wide_type hi, lo;
      hi = (wide_type'(1) <<< (COORD_BITS - 1)) - 1;
      lo = -(wide_type'(1) <<< (COORD_BITS - 1));
      if (v > hi) begin
         sat = 1'b1;
         v = hi;
      end else if (v < lo) begin
         sat = 1'b1;
         v = lo;
      end
      return v[31:0];
   endfunction

   function automatic crossing_type predict_crossing(logic [255:0] d, logic exact);
      wide_type ax1, ay1, ax2, ay2, bx1, by1, bx2, by2;
      wide_type adx, ady, bdx, bdy, ex, ey, dv, nm, mu;
      crossing_type c;
      logic sat;
      ax1 = field_coord(d[segi_pkg::CI_AX1*32 +: 32]);
      ay1 = field_coord(d[segi_pkg::CI_AY1*32 +: 32]);
      ax2 = field_coord(d[segi_pkg::CI_AX2*32 +: 32]);
      ay2 = field_coord(d[segi_pkg::CI_AY2*32 +: 32]);
      bx1 = field_coord(d[segi_pkg::CI_BX1*32 +: 32]);
      by1 = field_coord(d[segi_pkg::CI_BY1*32 +: 32]);
      bx2 = field_coord(d[segi_pkg::CI_BX2*32 +: 32]);
      by2 = field_coord(d[segi_pkg::CI_BY2*32 +: 32]);
      c = '0;
      sat = 1'b0;
      c.outcome = segi_pkg::OC_BOX_DISJOINT;
      if (exact && ((ax1 > ax2 ? ax1 : ax2) < (bx1 < bx2 ? bx1 : bx2) ||
                    (ax1 < ax2 ? ax1 : ax2) > (bx1 > bx2 ? bx1 : bx2) ||
                    (ay1 > ay2 ? ay1 : ay2) < (by1 < by2 ? by1 : by2) ||
                    (ay1 < ay2 ? ay1 : ay2) > (by1 > by2 ? by1 : by2))) begin
         c.outcome = segi_pkg::OC_BOX_DISJOINT;
      end else if ((ax1 == bx1 && ay1 == by1) || (ax1 == bx2 && ay1 == by2)) begin
         c.outcome = segi_pkg::OC_AT_START;
         c.cx = ax1[31:0];
         c.cy = ay1[31:0];
      end else if ((ax2 == bx1 && ay2 == by1) || (ax2 == bx2 && ay2 == by2)) begin
         c.outcome = segi_pkg::OC_AT_END;
         c.cx = ax2[31:0];
         c.cy = ay2[31:0];
      end else begin
         adx = ax2 - ax1;
         ady = ay2 - ay1;
         bdx = bx2 - bx1;
         bdy = by2 - by1;
         ex = bx1 - ax1;
         ey = by1 - ay1;
         dv = adx * bdy - bdx * ady;
         if (dv == 0) begin
            c.outcome = segi_pkg::OC_PARALLEL;
         end else begin
            nm = ex * bdy - bdx * ey;
            c.cx = clamp(ax1 + div_round(nm * adx, dv), sat);
            c.cy = clamp(ay1 + div_round(nm * ady, dv), sat);
            c.sat = sat;
            c.outcome = segi_pkg::OC_COMPUTED;
            if (exact) begin
               mu = ex * ady - adx * ey;
               if (!in_unit(nm, dv) || !in_unit(mu, dv)) c.outcome = segi_pkg::OC_OUTSIDE;
            end
         end
      end
      c.found = c.outcome inside {segi_pkg::OC_AT_START, segi_pkg::OC_AT_END,
                                  segi_pkg::OC_COMPUTED};
      return c;
   endfunction

   // Queue a prediction per accepted request, compare per accepted response
   always @(posedge clock) begin
      crossing_type exp_c;
      if (reset) begin
         crossing_q.delete();
         fail_count <= 0;
         rsp_seen <= 0;
         for (int i = 0; i < 6; i++) outcome_hits[i] <= 0;
      end else begin
         if (req_tvalid && req_tready)
            crossing_q.push_back(predict_crossing(req_tdata, req_tuser[0]));
         if (rsp_tvalid && rsp_tready) begin
            rsp_seen <= rsp_seen + 1;
            if (crossing_q.size() == 0) begin
               $error("response with no request outstanding");
               fail_count <= fail_count + 1;
            end else begin
               exp_c = crossing_q.pop_front();
               outcome_hits[exp_c.outcome] <= outcome_hits[exp_c.outcome] + 1;
               if (rsp_tdata[2:0] !== exp_c.outcome ||
                   rsp_tdata[3] !== exp_c.found ||
                   rsp_tdata[35:4] !== exp_c.cx ||
                   rsp_tdata[67:36] !== exp_c.cy ||
                   rsp_tdata[68] !== exp_c.sat) begin
                  fail_count <= fail_count + 1;
                  if (rsp_tdata[2:0] !== exp_c.outcome)
                     $error("outcome expected %0d got %0d", exp_c.outcome, rsp_tdata[2:0]);
                  if (rsp_tdata[3] !== exp_c.found)
                     $error("found expected %0d got %0d", exp_c.found, rsp_tdata[3]);
                  if (rsp_tdata[35:4] !== exp_c.cx)
                     $error("cross_x expected %0d got %0d", exp_c.cx,
                            $signed(rsp_tdata[35:4]));
                  if (rsp_tdata[67:36] !== exp_c.cy)
                     $error("cross_y expected %0d got %0d", exp_c.cy,
                            $signed(rsp_tdata[67:36]));
                  if (rsp_tdata[68] !== exp_c.sat)
                     $error("saturated expected %0d got %0d", exp_c.sat, rsp_tdata[68]);
               end
            end
         end
      end
   end

   assign pending = crossing_q.size();

endmodule

`default_nettype wire

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment intersection testbench
// Drives directed and random segment pairs with random gaps on both streams,
// long response back-pressure and a drain pause; the checker gives the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

   localparam int N_RANDOM = 1750;
   localparam int LATENCY  = 44;

   logic         clock;
   logic         reset;
   logic [255:0] req_tdata;
   logic [0:0]   req_tuser;
   logic         req_tvalid;
   logic         req_tready;
   logic [71:0]  rsp_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   int           fail_count;
   int           pending;
   int           rsp_seen;
   int           outcome_hits [6];
   logic         hold_off;
   int           rsp_wait;
   int           sent;

   segment_intersection_top dut (
      .clock(clock), .reset(reset),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tdata(rsp_tdata), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready)
   );

   segi_checker chk (
      .clock(clock), .reset(reset),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tdata(rsp_tdata), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .fail_count(fail_count), .pending(pending), .rsp_seen(rsp_seen),
      .outcome_hits(outcome_hits)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Pick a coordinate: extremes, small values or full random
   function automatic logic [31:0] pick_coord();
      case ($urandom_range(0, 9))
         0: return 32'h7fff_ffff;
         1: return 32'h8000_0000;
         2, 3: return 32'($signed($urandom_range(0, 40)) - 20);
         4, 5: return 32'($signed($urandom_range(0, 4000)) - 2000);
         default: return $urandom();
      endcase
   endfunction

   // Build a pair that often shares endpoints, runs parallel or has A as a single point
   function automatic logic [255:0] make_pair();
      logic [31:0] c [8];
      logic [255:0] d;
      for (int i = 0; i < 8; i++) c[i] = pick_coord();
      case ($urandom_range(0, 7))
         0: begin
            c[segi_pkg::CI_BX1] = c[segi_pkg::CI_AX1 + 2 * $urandom_range(0, 1)];
            c[segi_pkg::CI_BY1] = c[c[segi_pkg::CI_BX1] == c[segi_pkg::CI_AX1] ?
                                    segi_pkg::CI_AY1 : segi_pkg::CI_AY2];
         end
         1: begin
            c[segi_pkg::CI_BX2] = c[segi_pkg::CI_AX2];
            c[segi_pkg::CI_BY2] = c[segi_pkg::CI_AY2];
         end
         2: begin
            // parallel: B is A shifted
            c[segi_pkg::CI_BX2] = c[segi_pkg::CI_BX1] + c[segi_pkg::CI_AX2] -
                                  c[segi_pkg::CI_AX1];
            c[segi_pkg::CI_BY2] = c[segi_pkg::CI_BY1] + c[segi_pkg::CI_AY2] -
                                  c[segi_pkg::CI_AY1];
         end
         3: begin
            c[segi_pkg::CI_AX2] = c[segi_pkg::CI_AX1];
            c[segi_pkg::CI_AY2] = c[segi_pkg::CI_AY1];
         end
         default: ;
      endcase
      for (int i = 0; i < 8; i++) d[i*32 +: 32] = c[i];
      return d;
   endfunction

   task automatic send_pair(logic [255:0] d, logic exact);
      req_tdata  <= d;
      req_tuser  <= exact;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent++;
   endtask

   task automatic send_gap();
      int gap;
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic logic [255:0] pack8(int ax1, int ay1, int ax2, int ay2,
                                         int bx1, int by1, int bx2, int by2);
      return {32'(by2), 32'(bx2), 32'(by1), 32'(bx1),
              32'(ay2), 32'(ax2), 32'(ay1), 32'(ax1)};
   endfunction

   // Response side: idle a drawn number of cycles per response, plus a long hold-off
   always @(posedge clock) begin
      int draw;
      if (reset || hold_off) begin
         rsp_tready <= 1'b0;
         rsp_wait   <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         draw = $urandom_range(0, 11);
         rsp_wait   <= draw;
         rsp_tready <= (draw == 0);
      end else if (rsp_wait > 0) begin
         rsp_wait   <= rsp_wait - 1;
         rsp_tready <= (rsp_wait == 1);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   initial begin
      hold_off = 1'b0;
      @(negedge reset);
      repeat (600) @(posedge clock);
      hold_off <= 1'b1;
      repeat (300) @(posedge clock);
      hold_off <= 1'b0;
   end

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= '0;
      sent       = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: crossing, rounding, shared endpoints, parallel, disjoint, a point segment, extremes
      for (int e = 0; e < 2; e++) begin
         send_pair(pack8(0, 0, 10, 10, 0, 10, 10, 0), 1'(e));
         send_pair(pack8(0, 0, 3, 1, 0, 1, 1, 0), 1'(e));
         send_pair(pack8(1, 1, 5, 5, 1, 1, 9, 0), 1'(e));
         send_pair(pack8(1, 1, 5, 5, 9, 0, 5, 5), 1'(e));
         send_pair(pack8(0, 0, 4, 4, 1, 0, 5, 4), 1'(e));
         send_pair(pack8(0, 0, 1, 1, 5, 0, 6, 2), 1'(e));
         send_pair(pack8(0, 0, 1, 1, 50, 60, 70, 90), 1'(e));
         send_pair(pack8(3, 3, 3, 3, 0, 0, 1, 7), 1'(e));
         send_pair(pack8(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff,
                         32'h80000000, 32'h80000000, 32'h7ffffffe, 32'h7fffffff), 1'(e));
         send_pair(pack8(0, 0, 1, 1, 32'h7fffffff, 0, 32'h7ffffffe, 2), 1'(e));
         send_pair(pack8(-1, -1, -3, -2, 1, -5, -6, 0), 1'(e));
      end
      req_tvalid <= 1'b0;

      // random pairs; pause once midway until everything has drained
      for (int n = 0; n < N_RANDOM; n++) begin
         if (n == N_RANDOM / 2) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
            while (pending != 0) @(posedge clock);
         end
         send_pair(make_pair(), $urandom_range(0, 2) != 0);
         send_gap();
      end
      req_tvalid <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      $display("Sent %0d segment pairs, %0d responses checked", sent, rsp_seen);
      $display("Outcomes disjoint/parallel/outside/start/end/computed: %0d %0d %0d %0d %0d %0d",
               outcome_hits[0], outcome_hits[1], outcome_hits[2],
               outcome_hits[3], outcome_hits[4], outcome_hits[5]);
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #2_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule

`default_nettype wire

// File: sim.f
rtl/segi_pkg.sv
rtl/segi_front.sv
rtl/segi_scale.sv
rtl/segi_div.sv
rtl/segment_intersection_top.sv
dv/segi_checker.sv
dv/tb_top.sv
